>>> design/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, widths and codes for the table position interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TIME_W  = 48;
  localparam int POS_W   = 48;
  localparam int COUNT_W = 11;

  // multiply / divide unit
  localparam int MAG_W     = 48;
  localparam int HALF_W    = MAG_W / 2;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int MUL_STEPS = 4;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int QUO_W     = 53;
  localparam int QUOT_W    = 52;
  localparam logic [QUO_W-1:0] QUOT_CAP = QUO_W'(1) << 51;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REWIND = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  typedef struct packed {
    logic        [1:0]       opcode;
    logic        [9:0]       entry_index;
    logic        [TIME_W-1:0] sample_time;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } req_item_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic        [TIME_W-1:0] echo_time;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
  } rsp_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] mag_d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } md_res_t;

  // entry_count values above the depth act as the depth
  function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] ec);
    if (int'(ec) > TABLE_DEPTH) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(ec);
  endfunction

endpackage

`default_nettype wire

>>> design/table_position_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_position_interpolator_top
// Position table with cursor search and linear interpolation of x, y, z.
// ----------------------------------------------------------------------------
`default_nettype none

// Load items write one table entry and rewind items clear the search cursor;
// both are handled in the idle state. A query walks the table upward from
// the cursor, reading each entry through the single RAM read port (S_RD) and
// comparing it (S_CMP), after first fetching the entry before the cursor when
// the cursor is not zero. It then runs each axis through the one shared
// multiply/divide unit: partial products, then one-bit division of the 96-bit
// product; an axis whose two entry times are equal skips the unit. A query
// that ends in below_range or beyond_range skips the arithmetic. The input is
// stalled while a query is at work. Results wait in an output register, so
// the next item is taken while one is still unread.

module table_position_interpolator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  tpi_pkg::req_item_t         req_item,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output tpi_pkg::rsp_item_t         rsp_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tpi_pkg::COUNT_W-1:0] cfg_data
);

  import tpi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_AXIS = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  logic [2:0]         state;
  logic [COUNT_W-1:0] entry_count;
  logic [IDX_W-1:0]   cursor;
  logic [CNT_W-1:0]   scan_idx;
  logic               priming;
  logic [1:0]         axis;
  entry_t             prev;
  entry_t             cur;
  logic               dq_neg;
  logic               dt_neg;
  logic               dt_zero;
  logic               dy_neg;
  logic [MAG_W-1:0]   dq_mag;
  logic [MAG_W-1:0]   dt_mag;
  rsp_item_t          res;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cursor_ext;
  logic [CNT_W-1:0]   scan_inc;
  logic [ENTRY_W-1:0] ram_rd_data;
  entry_t             rd_entry;
  logic               match;
  logic               ram_wr_en;
  logic [TIME_W:0]    dq;
  logic [TIME_W:0]    dt;
  logic [TIME_W:0]    dq_inv;
  logic [TIME_W:0]    dt_inv;
  logic [POS_W-1:0]   y0;
  logic [POS_W-1:0]   y1;
  logic [POS_W:0]     dy;
  logic [POS_W:0]     dy_inv;
  logic [MAG_W-1:0]   dy_mag;
  logic               neg;
  logic [QUO_W-1:0]   s_mag;
  logic [QUO_W-1:0]   s_val;
  logic [QUO_W-1:0]   sum;
  logic [POS_W-1:0]   lerp_sat;
  logic [POS_W-1:0]   axis_val;
  md_req_t            md_req;
  md_res_t            md_res;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    count      = clamp_count(entry_count);
    cursor_ext = CNT_W'(cursor);
    scan_inc   = scan_idx + 1'b1;
    rd_entry   = entry_t'(ram_rd_data);
    match      = res.echo_time < rd_entry.sample_time;
    ram_wr_en  = (state == S_IDLE) && req_valid && (req_item.opcode == OP_LOAD) &&
                 (int'(req_item.entry_index) < TABLE_DEPTH);

    dq     = {1'b0, res.echo_time} - {1'b0, prev.sample_time};
    dt     = {1'b0, rd_entry.sample_time} - {1'b0, prev.sample_time};
    dq_inv = -dq;
    dt_inv = -dt;

    case (axis)
      2'd0: begin
        y0 = prev.pos_x;
        y1 = cur.pos_x;
      end
      2'd1: begin
        y0 = prev.pos_y;
        y1 = cur.pos_y;
      end
      default: begin
        y0 = prev.pos_z;
        y1 = cur.pos_z;
      end
    endcase
    dy     = {y1[POS_W-1], y1} - {y0[POS_W-1], y0};
    dy_inv = -dy;
    dy_mag = dy[POS_W] ? dy_inv[MAG_W-1:0] : dy[MAG_W-1:0];

    // y0 +/- capped quotient, then clip to the signed 48-bit range
    neg   = dy_neg ^ dq_neg ^ dt_neg;
    s_mag = {1'b0, md_res.quot};
    s_val = neg ? -s_mag : s_mag;
    sum   = {{(QUO_W-POS_W){y0[POS_W-1]}}, y0} + s_val;
    if (sum[QUO_W-1] && !(&sum[QUO_W-2:POS_W-1])) begin
      lerp_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else if (!sum[QUO_W-1] && (|sum[QUO_W-2:POS_W-1])) begin
      lerp_sat = {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      lerp_sat = sum[POS_W-1:0];
    end
    axis_val = (state == S_AXIS) ? y0 : lerp_sat;

    md_req.start = (state == S_AXIS) && !dt_zero;
    md_req.mag_a = dy_mag;
    md_req.mag_b = dq_mag;
    md_req.mag_d = dt_mag;
  end

  tpi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (IDX_W'(req_item.entry_index)),
    .wr_data ({req_item.sample_time, req_item.pos_x, req_item.pos_y, req_item.pos_z}),
    .rd_en   (state == S_RD),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  tpi_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .res (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      cursor      <= '0;
      scan_idx    <= '0;
      priming     <= 1'b0;
      axis        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        entry_count <= cfg_data;
      end
      // S_OUT decides rsp_valid itself when it runs
      if (rsp_valid && !rsp_stall && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req_item.opcode)
              OP_REWIND: cursor <= '0;
              OP_QUERY: begin
                res.status    <= ST_BEYOND;
                res.echo_time <= req_item.sample_time;
                res.out_x     <= '0;
                res.out_y     <= '0;
                res.out_z     <= '0;
                if ((count < CNT_W'(2)) || (cursor_ext >= count)) begin
                  state <= S_OUT;
                end else if (cursor == '0) begin
                  scan_idx <= '0;
                  priming  <= 1'b0;
                  state    <= S_RD;
                end else begin
                  // fetch the entry before the cursor as the lower bound
                  scan_idx <= cursor_ext - 1'b1;
                  priming  <= 1'b1;
                  state    <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end

        S_RD: state <= S_CMP;

        S_CMP: begin
          if (priming) begin
            prev     <= rd_entry;
            priming  <= 1'b0;
            scan_idx <= scan_inc;
            state    <= S_RD;
          end else if (match) begin
            if (scan_idx == '0) begin
              res.status <= ST_BELOW;
              state      <= S_OUT;
            end else begin
              res.status <= ST_OK;
              cur        <= rd_entry;
              dq_neg     <= dq[TIME_W];
              dt_neg     <= dt[TIME_W];
              dt_zero    <= (dt == '0);
              dq_mag     <= dq[TIME_W] ? dq_inv[MAG_W-1:0] : dq[MAG_W-1:0];
              dt_mag     <= dt[TIME_W] ? dt_inv[MAG_W-1:0] : dt[MAG_W-1:0];
              cursor     <= IDX_W'(scan_idx - 1'b1);
              axis       <= '0;
              state      <= S_AXIS;
            end
          end else begin
            prev <= rd_entry;
            if (scan_inc >= count) begin
              state <= S_OUT;
            end else begin
              scan_idx <= scan_inc;
              state    <= S_RD;
            end
          end
        end

        S_AXIS, S_WAIT: begin
          if (state == S_AXIS) begin
            dy_neg <= dy[POS_W];
          end
          if ((state == S_AXIS && dt_zero) || (state == S_WAIT && md_res.done)) begin
            case (axis)
              2'd0:    res.out_x <= axis_val;
              2'd1:    res.out_y <= axis_val;
              default: res.out_z <= axis_val;
            endcase
            if (axis == AXIS_LAST) begin
              state <= S_OUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_AXIS;
            end
          end else if (state == S_AXIS) begin
            state <= S_WAIT;
          end
        end

        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_item  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a table read never goes past the active entry count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (scan_idx < count))
    else $error("table read past entry count");

  // the shared unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_res.done |-> (state == S_WAIT))
    else $error("muldiv result outside wait state");

  // a match moves the cursor to an entry inside the table
  a_cursor_moved: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && !priming && match && scan_idx != '0)
      |=> (cursor_ext < count) && (state == S_AXIS))
    else $error("cursor update out of range");

endmodule

`default_nettype wire

>>> design/tpi_ram.sv
// ----------------------------------------------------------------------------
// tpi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/tpi_muldiv.sv
// ----------------------------------------------------------------------------
// tpi_muldiv
// Iterative unit: exact a*b over four 24x24 partial products, then a
// restoring divide by d one quotient bit per cycle, quotient capped at 2^51.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  tpi_pkg::md_req_t req,
  output tpi_pkg::md_res_t res
);

  import tpi_pkg::*;

  logic              busy;
  logic              in_div;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  a_reg;
  logic [MAG_W-1:0]  b_reg;
  logic [MAG_W-1:0]  d_reg;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;

  logic [HALF_W-1:0]   a_part;
  logic [HALF_W-1:0]   b_part;
  logic [2*HALF_W-1:0] pp;
  logic [1:0]          shift_sel;
  logic [PROD_W-1:0]   add_term;
  logic [MAG_W:0]      rem_sh;
  logic                ge;
  logic [MAG_W:0]      rem_sub;
  logic [QUO_W-1:0]    quo_sh;

  always_comb begin
    a_part    = step[1] ? a_reg[MAG_W-1:HALF_W] : a_reg[HALF_W-1:0];
    b_part    = step[0] ? b_reg[MAG_W-1:HALF_W] : b_reg[HALF_W-1:0];
    pp        = a_part * b_part;
    shift_sel = 2'(step[1]) + 2'(step[0]);
    case (shift_sel)
      2'd0:    add_term = PROD_W'(pp);
      2'd1:    add_term = PROD_W'(pp) << HALF_W;
      default: add_term = PROD_W'(pp) << (2 * HALF_W);
    endcase

    rem_sh  = {rem, prod[PROD_W-1]};
    ge      = rem_sh >= {1'b0, d_reg};
    rem_sub = rem_sh - {1'b0, d_reg};
    quo_sh  = {quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      in_div <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          a_reg  <= req.mag_a;
          b_reg  <= req.mag_b;
          d_reg  <= req.mag_d;
          prod   <= '0;
          rem    <= '0;
          quo    <= '0;
          step   <= '0;
          in_div <= 1'b0;
          busy   <= 1'b1;
        end
      end else if (!in_div) begin
        prod <= prod + add_term;
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          step   <= '0;
          in_div <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end else begin
        prod <= {prod[PROD_W-2:0], 1'b0};
        rem  <= ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        quo  <= (quo_sh > QUOT_CAP) ? QUOT_CAP : quo_sh;
        if (step == STEP_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quo[QUOT_W-1:0];

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load, query and rewind items into the table position interpolator
// and predicts every query result (status, echoed time, interpolated x/y/z).
// A short directed run covers the corner cases. Random phases then follow,
// each setting its entry count from a plan. Sender bursts and receiver stalls are
// random. A watchdog ends a hung run.
// ----------------------------------------------------------------------------

module tb_top;
  import tpi_pkg::*;

  localparam int DRAIN_CYCLES = 400;    // above the base latency of one query
  localparam int IDLE_LIMIT   = 20000;  // a full-depth walk plus arithmetic, several times
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [POS_W-1:0] POS_HI = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_LO = {1'b1, {(POS_W-1){1'b0}}};
  localparam longint P_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint P_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [TIME_W-1:0] T_ONE = TIME_W'(1) << 24;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_LONG} rx_mode_t;

  // Shadow of the table and cursor, plus the queue of predicted query results.
  class interp_scoreboard;
    logic [TIME_W-1:0] tab_time [TABLE_DEPTH];
    logic [POS_W-1:0]  tab_x    [TABLE_DEPTH];
    logic [POS_W-1:0]  tab_y    [TABLE_DEPTH];
    logic [POS_W-1:0]  tab_z    [TABLE_DEPTH];
    int unsigned       cursor;
    int unsigned       entry_count;
    rsp_item_t         expected_q [$];
    int                errors;

    function new();
      cursor      = 0;
      entry_count = 0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // p0 + (p1-p0)*dq/dt, exact product, quotient capped, sum saturated
    function logic [POS_W-1:0] interp_axis(input logic [POS_W-1:0] p0,
                                           input logic [POS_W-1:0] p1,
                                           input longint dq, input longint dt);
      longint       y0, y1, dy, s, r;
      logic [63:0]  m_dy, m_dq, m_dt;
      logic [127:0] quot;
      bit           neg;
      y0 = $signed(p0);
      y1 = $signed(p1);
      if (dt == 0) begin
        return p0;
      end
      dy   = y1 - y0;
      m_dy = (dy < 0) ? -dy : dy;
      m_dq = (dq < 0) ? -dq : dq;
      m_dt = (dt < 0) ? -dt : dt;
      quot = ({64'd0, m_dy} * {64'd0, m_dq}) / {64'd0, m_dt};
      if (quot > (128'd1 << 51)) begin
        quot = 128'd1 << 51;
      end
      neg = ((dy < 0) != (dq < 0)) ^ (dt < 0);
      s = neg ? -$signed(quot[63:0]) : $signed(quot[63:0]);
      r = y0 + s;
      if (r > P_MAX) begin
        r = P_MAX;
      end
      if (r < P_MIN) begin
        r = P_MIN;
      end
      return r[POS_W-1:0];
    endfunction

    function void note_input(input req_item_t it);
      rsp_item_t   e;
      int unsigned n, j, hit, p;
      bit          found;
      longint      dq, dt;
      case (it.opcode)
        OP_LOAD: begin
          tab_time[it.entry_index] = it.sample_time;
          tab_x[it.entry_index]    = it.pos_x;
          tab_y[it.entry_index]    = it.pos_y;
          tab_z[it.entry_index]    = it.pos_z;
        end
        OP_REWIND: begin
          cursor = 0;
        end
        OP_QUERY: begin
          e.status    = ST_BEYOND;
          e.echo_time = it.sample_time;
          e.out_x     = '0;
          e.out_y     = '0;
          e.out_z     = '0;
          n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
          found = 1'b0;
          hit   = 0;
          if (n >= 2) begin
            for (j = cursor; j < n && !found; j++) begin
              if (it.sample_time < tab_time[j]) begin
                found = 1'b1;
                hit   = j;
              end
            end
          end
          if (found && hit == 0) begin
            e.status = ST_BELOW;
          end else if (found) begin
            p  = hit - 1;
            dq = $signed({16'd0, it.sample_time}) - $signed({16'd0, tab_time[p]});
            dt = $signed({16'd0, tab_time[hit]}) - $signed({16'd0, tab_time[p]});
            e.status = ST_OK;
            e.out_x  = interp_axis(tab_x[p], tab_x[hit], dq, dt);
            e.out_y  = interp_axis(tab_y[p], tab_y[hit], dq, dt);
            e.out_z  = interp_axis(tab_z[p], tab_z[hit], dq, dt);
            cursor   = p;
          end
          expected_q = {expected_q, e};
        end
        default: ;
      endcase
    endfunction

    function void compare_field(input string name, input logic [TIME_W-1:0] want,
                                input logic [TIME_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(input rsp_item_t got);
      rsp_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", TIME_W'(e.status), TIME_W'(got.status));
      compare_field("echo_time", e.echo_time, got.echo_time);
      compare_field("out_x", e.out_x, got.out_x);
      compare_field("out_y", e.out_y, got.out_y);
      compare_field("out_z", e.out_z, got.out_z);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_item_t          req_item  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_item_t          rsp_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  interp_scoreboard sb;
  int               burst_left = 0;
  rx_mode_t         stall_mode = RX_FREE;
  int               stall_left = 0;

  table_position_interpolator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall pattern changes to a random mode when its run count expires
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 4));
      stall_left = $urandom_range(16, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_FREE:     rsp_stall <= 1'b0;
      RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:    rsp_stall <= ($urandom_range(0, 1) == 0);
      RX_PERIODIC: rsp_stall <= (stall_left % 7 < 4);
      default:     rsp_stall <= (stall_left % 40 < 30);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_result(rsp_item);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[table_position_interpolator_top] ERROR");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       return POS_HI;
      1:       return POS_LO;
      2:       return {{16{w[31]}}, w};
      default: return rand48();
    endcase
  endfunction

  function automatic req_item_t load_item(input int unsigned idx, input logic [TIME_W-1:0] t,
                                          input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                          input logic [POS_W-1:0] z);
    req_item_t it;
    it.opcode      = OP_LOAD;
    it.entry_index = 10'(idx);
    it.sample_time = t;
    it.pos_x       = x;
    it.pos_y       = y;
    it.pos_z       = z;
    return it;
  endfunction

  // unused fields carry random bits
  function automatic req_item_t plain_item(input logic [1:0] op, input logic [TIME_W-1:0] t);
    req_item_t it;
    it.opcode      = op;
    it.entry_index = 10'($urandom);
    it.sample_time = t;
    it.pos_x       = rand48();
    it.pos_y       = rand48();
    it.pos_z       = rand48();
    return it;
  endfunction

  task automatic push_item(input req_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_item  <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_input(it);
  endtask

  task automatic pause_for_results();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // loads and rewinds leave no result, so let them settle too
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned v);
    wait_drained();
    cfg_data  <= COUNT_W'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.entry_count = v;
  endtask

  // ascending times, with an occasional repeated time
  task automatic build_table(input int unsigned n);
    logic [TIME_W-1:0] t;
    logic [63:0]       step;
    t = rand48() >> $urandom_range(2, 24);
    for (int unsigned i = 0; i < n; i++) begin
      push_item(load_item(i, t, rand_pos(), rand_pos(), rand_pos()));
      step = {$urandom, $urandom};
      step = ($urandom_range(0, 15) == 0) ? 64'd0 : (step & 64'hF_FFFF_FFFF) + 64'd1;
      t = t + step[TIME_W-1:0];
    end
  endtask

  task automatic run_phase(input int unsigned count_val, input int items, input bit rebuild);
    int unsigned       n, qk, slot;
    logic [TIME_W-1:0] t;
    int                r, done;
    n = (count_val < 2) ? 2 : count_val;
    if (rebuild) begin
      build_table(n);
    end
    write_count(count_val);
    qk   = 0;
    done = 0;
    while (done < items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // walk forward through the table
        qk = qk + $urandom_range(0, n / 8 + 1);
        if (qk >= n) begin
          if ($urandom_range(0, 1) == 1) begin
            push_item(plain_item(OP_REWIND, rand48()));
            qk = 0;
          end else begin
            qk = n - 1;
          end
        end
        t = sb.tab_time[qk];
        if ($urandom_range(0, 5) != 0) begin
          t = t + TIME_W'($urandom & 32'h3FF_FFFF);
        end
        push_item(plain_item(OP_QUERY, t));
      end else if (r < 63) begin
        push_item(plain_item(OP_REWIND, rand48()));
        qk = 0;
      end else if (r < 70) begin
        push_item(plain_item(OP_QUERY, sb.tab_time[0] >> $urandom_range(1, 8)));
      end else if (r < 78) begin
        slot = $urandom_range(0, n - 1);
        push_item(load_item(slot, sb.tab_time[slot], rand_pos(), rand_pos(), rand_pos()));
      end else if (r < 85) begin
        push_item(load_item($urandom_range(0, TABLE_DEPTH - 1), rand48(), rand_pos(),
                            rand_pos(), rand_pos()));
      end else if (r < 93) begin
        push_item(plain_item(OP_QUERY, rand48()));
      end else if (r < 96) begin
        push_item(plain_item(OP_UNUSED, rand48()));
      end else begin
        pause_for_results();
      end
      if (r < 93) begin
        done++;
      end
    end
  endtask

  initial begin
    int unsigned plan [14];
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: too few entries at reset count
    push_item(plain_item(OP_QUERY, 5 * T_ONE));
    push_item(load_item(0, T_ONE,     POS_HI, POS_LO, '0));
    push_item(load_item(1, 3 * T_ONE, POS_LO, POS_HI, '1));
    push_item(load_item(2, 3 * T_ONE, 48'sd100, -48'sd100, 48'h1234_5678_9ABC));
    push_item(load_item(3, 5 * T_ONE, POS_HI, '0, POS_LO));
    push_item(load_item(4, 2 * T_ONE, POS_LO, -48'sd5, POS_HI));  // out of order
    push_item(load_item(5, T_MAX, 48'sd1, 48'sd2, 48'sd3));
    write_count(1);
    push_item(plain_item(OP_QUERY, 2 * T_ONE));
    write_count(6);
    push_item(plain_item(OP_QUERY, '0));          // before first entry
    push_item(plain_item(OP_QUERY, T_ONE));       // exactly on entry 0
    push_item(plain_item(OP_QUERY, 2 * T_ONE));
    push_item(plain_item(OP_QUERY, 3 * T_ONE));   // skips both equal entries, cursor to 2
    push_item(plain_item(OP_QUERY, T_ONE));       // equal times around the cursor
    push_item(plain_item(OP_QUERY, 6 * T_ONE));   // cursor to 4
    push_item(plain_item(OP_QUERY, T_ONE));       // descending pair, saturates
    push_item(plain_item(OP_QUERY, '0));
    push_item(plain_item(OP_QUERY, T_MAX));       // beyond the last entry
    push_item(plain_item(OP_REWIND, '0));
    push_item(plain_item(OP_UNUSED, T_MAX));
    push_item(plain_item(OP_QUERY, T_MAX - 1));
    write_count(3);                               // cursor now past the count
    push_item(plain_item(OP_QUERY, '0));
    push_item(plain_item(OP_REWIND, T_MAX));
    push_item(plain_item(OP_QUERY, '0));

    plan[0]  = 2;
    plan[1]  = 3;
    plan[2]  = $urandom_range(4, 16);
    plan[3]  = 0;
    plan[4]  = $urandom_range(2, 40);
    plan[5]  = 1;
    plan[6]  = $urandom_range(4, 16);
    plan[7]  = 192;
    plan[8]  = 191;                               // reuses the table of the phase before
    plan[9]  = $urandom_range(17, 64);
    plan[10] = 2;
    plan[11] = $urandom_range(4, 16);
    plan[12] = 3;
    plan[13] = $urandom_range(2, 40);
    for (int p = 0; p < 14; p++) begin
      run_phase(plan[p], (plan[p] > 64) ? 12 : 28, p != 8);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("[table_position_interpolator_top] OK");
    end else begin
      $display("[table_position_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
